// ===== sv/scm_pkg.sv =====
`timescale 1ns / 1ps
package scm_pkg;

  // fixed formats
  localparam int ANGLE_BITS     = 32;
  localparam int TRIG_FRAC_BITS = 30;
  localparam int TRIG_W         = TRIG_FRAC_BITS + 2;
  localparam int PROD_W         = TRIG_W + 1;
  localparam int WORK_BITS      = 60;
  localparam int PHASE_W        = 64;
  localparam int CNT_W          = $clog2(WORK_BITS);
  localparam int MAX_CONES_DEF  = 64;
  localparam int NUM_W          = 6;
  localparam int ACTIVE_W       = 7;
  localparam int INDEX_W        = 8;
  localparam int CFG_IDX_W      = 2;
  localparam int CFG_DATA_W     = 7;
  localparam int ENTRY_W        = ANGLE_BITS + 3 * TRIG_W;

  localparam logic [INDEX_W-1:0] NO_MATCH = '1;

  localparam logic [63:0] INV_TWO_PI_Q64 = 64'h28BE60DB9391054A;
  localparam logic [63:0] GAIN_SEED      = 64'h9B74EDA8 << 28;

  typedef enum logic [1:0] {
    OP_LOAD = 2'd0,
    OP_FIND = 2'd1,
    OP_EACH = 2'd2,
    OP_NONE = 2'd3
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ORIGIN = 2'd0,
    REG_ACTIVE = 2'd1
  } reg_idx_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_LD_DEC_GO,
    S_LD_DEC_RUN,
    S_LD_RAD_GO,
    S_LD_RAD_RUN,
    S_LD_WRITE,
    S_SRC_GO,
    S_SRC_RUN,
    S_RD_CONE,
    S_CONE_GO,
    S_CONE_RUN,
    S_MUL_P1,
    S_MUL_A,
    S_MUL_P2,
    S_CHECK,
    S_OUT
  } state_t;

  typedef logic [WORK_BITS-1:0][63:0] atan_tab_t;

  // (a*b) >> s, truncated to 64 bits
  function automatic logic [63:0] mul_shift(input logic [63:0] a, input logic [63:0] b,
                                            input int s);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    return 64'(p >> s);
  endfunction

  // atan(2^-i) as a 64-bit turn fraction
  function automatic atan_tab_t build_atan();
    atan_tab_t  tab;
    logic [63:0] acc;
    logic [63:0] term;
    tab[0] = 64'd1 << 61;
    for (int i = 1; i < WORK_BITS; i++) begin
      acc = '0;
      for (int k = 0; i * (2 * k + 1) <= 62; k++) begin
        term = (64'd1 << (62 - i * (2 * k + 1))) / 64'(2 * k + 1);
        if (k % 2 == 1) acc = acc - term;
        else acc = acc + term;
      end
      tab[i] = mul_shift(acc, INV_TWO_PI_Q64, 62);
    end
    return tab;
  endfunction

  // cordic gain in Q60 by newton steps for 1/sqrt(p)
  function automatic logic [63:0] build_gain();
    logic [63:0] p;
    logic [63:0] y;
    logic [63:0] t;
    p = 64'd1 << WORK_BITS;
    for (int i = 0; i < WORK_BITS && 2 * i < 64; i++) p = p + (p >> (2 * i));
    y = GAIN_SEED;
    for (int k = 0; k < 4; k++) begin
      t = mul_shift(y, y, WORK_BITS);
      t = mul_shift(t, p, WORK_BITS);
      y = mul_shift(y, (64'd3 << WORK_BITS) - t, WORK_BITS + 1);
    end
    return y;
  endfunction

  localparam atan_tab_t   ATAN_TAB = build_atan();
  localparam logic [63:0] GAIN_Q60 = build_gain();

endpackage

// ===== sv/scm_cordic.sv =====
`timescale 1ns / 1ps
module scm_cordic (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  input  logic [scm_pkg::PHASE_W-1:0]         phase,
  output logic                                done,
  output logic signed [scm_pkg::TRIG_W-1:0]   cos_out,
  output logic signed [scm_pkg::TRIG_W-1:0]   sin_out
);
  import scm_pkg::*;

  logic               running;
  logic [CNT_W-1:0]   cnt;
  logic signed [63:0] x;
  logic signed [63:0] y;
  logic [63:0]        z;
  logic               neg;
  logic               neg_in;
  logic signed [63:0] dx;
  logic signed [63:0] dy;

  // round q60 to trig format, clamp, apply half-turn sign
  function automatic logic signed [TRIG_W-1:0] to_trig(input logic signed [63:0] v,
                                                       input logic n);
    logic signed [63:0] r;
    logic signed [63:0] one;
    one = 64'sd1 <<< TRIG_FRAC_BITS;
    r = (v + (64'sd1 <<< (WORK_BITS - TRIG_FRAC_BITS - 1))) >>> (WORK_BITS - TRIG_FRAC_BITS);
    if (r > one) r = one;
    if (r < -one) r = -one;
    if (n) r = -r;
    return TRIG_W'(r);
  endfunction

  assign neg_in = phase[63] ^ phase[62];
  assign dx     = y >>> cnt;
  assign dy     = x >>> cnt;

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      cnt     <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        running <= 1'b1;
        cnt     <= '0;
      end else if (running) begin
        if (cnt == CNT_W'(WORK_BITS - 1)) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
        cnt <= cnt + 1'b1;
      end
    end
  end

  // one micro-rotation per cycle
  always_ff @(posedge clk) begin
    if (start) begin
      neg <= neg_in;
      x   <= signed'(GAIN_Q60);
      y   <= '0;
      z   <= {phase[63] ^ neg_in, phase[62:0]};
    end else if (running) begin
      if (!z[63]) begin
        x <= x - dx;
        y <= y + dy;
        z <= z - ATAN_TAB[cnt];
      end else begin
        x <= x + dx;
        y <= y - dy;
        z <= z + ATAN_TAB[cnt];
      end
    end
  end

  assign cos_out = to_trig(x, neg);
  assign sin_out = to_trig(y, neg);

endmodule

// ===== sv/scm_table.sv =====
`timescale 1ns / 1ps
module scm_table #(
  parameter int DEPTH = scm_pkg::MAX_CONES_DEF,
  parameter int AW    = 6
) (
  input  logic                        clk,
  input  logic                        we,
  input  logic [AW-1:0]               waddr,
  input  logic [scm_pkg::ENTRY_W-1:0] wdata,
  input  logic [AW-1:0]               raddr,
  output logic [scm_pkg::ENTRY_W-1:0] rdata
);
  import scm_pkg::*;

  logic [ENTRY_W-1:0] mem [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

endmodule

// ===== sv/sky_cone_match_top.sv =====
`timescale 1ns / 1ps
// load item: two 60-step cordic runs and a table write, no result
// query: a cordic run for the source declination, then for each cone examined a 60-step
// cordic run and three passes through the shared multiplier
// one item at a time: in_ready is high only when no item is in progress
// synchronous reset clears the sequencer and both registers; the cone table is not cleared
module sky_cone_match_top #(
  parameter int MAX_CONES = scm_pkg::MAX_CONES_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic [1:0]                            operation,
  input  logic [scm_pkg::NUM_W-1:0]             entry_index,
  input  logic signed [scm_pkg::ANGLE_BITS-1:0] ra_angle,
  input  logic signed [scm_pkg::ANGLE_BITS-1:0] dec_angle,
  input  logic signed [scm_pkg::ANGLE_BITS-1:0] radius_angle,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic                                  any_match,
  output logic signed [scm_pkg::INDEX_W-1:0]    match_index,
  output logic                                  cone_flag,
  output logic [scm_pkg::NUM_W-1:0]             cone_number,
  output logic                                  last,
  input  logic                                  cfg_write,
  input  logic [scm_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [scm_pkg::CFG_DATA_W-1:0]        cfg_data
);
  import scm_pkg::*;

  localparam int AW = (MAX_CONES > 1) ? $clog2(MAX_CONES) : 1;

  state_t state, state_next;

  logic                    origin;
  logic [ACTIVE_W-1:0]     active;
  logic [ACTIVE_W-1:0]     n_eff;
  logic [AW-1:0]           idx;
  logic [AW-1:0]           idx_next;
  logic                    in_acc;
  logic                    out_acc;
  logic                    slot_ok;
  logic                    last_cone;
  logic                    hit;

  logic [1:0]              op_r;
  logic [NUM_W-1:0]        slot_r;
  logic [ANGLE_BITS-1:0]   ra_r;
  logic [ANGLE_BITS-1:0]   dec_r;
  logic [ANGLE_BITS-1:0]   rad_r;

  logic                    c_start;
  logic [PHASE_W-1:0]      c_phase;
  logic                    c_done;
  logic signed [TRIG_W-1:0] c_cos;
  logic signed [TRIG_W-1:0] c_sin;

  logic signed [TRIG_W-1:0] ld_cos;
  logic signed [TRIG_W-1:0] ld_sin;
  logic signed [TRIG_W-1:0] src_cos;
  logic signed [TRIG_W-1:0] src_sin;
  logic signed [TRIG_W-1:0] cdra;

  logic                    tb_we;
  logic [ENTRY_W-1:0]      tb_wdata;
  logic [ENTRY_W-1:0]      tb_rdata;
  logic [ANGLE_BITS-1:0]   cone_ra;
  logic signed [TRIG_W-1:0] cone_sd;
  logic signed [TRIG_W-1:0] cone_cd;
  logic signed [TRIG_W-1:0] cone_cr;

  logic signed [PROD_W-1:0] mul_a;
  logic signed [PROD_W-1:0] mul_b;
  logic signed [PROD_W-1:0] mul_round;
  logic signed [PROD_W-1:0] prod_r;
  logic signed [PROD_W-1:0] p1_r;
  logic [PROD_W-2:0]        mag_a;
  logic [PROD_W-2:0]        mag_b;
  logic [2*PROD_W-3:0]      mag_p;
  logic [2*PROD_W-3:0]      mag_r;
  logic signed [PROD_W+1:0] rhs;

  assign in_acc  = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;
  assign n_eff   = (active > ACTIVE_W'(MAX_CONES)) ? ACTIVE_W'(MAX_CONES) : active;
  assign slot_ok = ACTIVE_W'(entry_index) < ACTIVE_W'(MAX_CONES);
  assign last_cone = (ACTIVE_W'(idx) + 1'b1) == n_eff;

  // cordic unit shared by all angle work
  scm_cordic u_cordic (
    .clk     (clk),
    .rst     (rst),
    .start   (c_start),
    .phase   (c_phase),
    .done    (c_done),
    .cos_out (c_cos),
    .sin_out (c_sin)
  );

  // cone table
  assign tb_wdata = {ra_r, ld_sin, ld_cos, c_cos};
  scm_table #(.DEPTH(MAX_CONES), .AW(AW)) u_table (
    .clk   (clk),
    .we    (tb_we),
    .waddr (slot_r[AW-1:0]),
    .wdata (tb_wdata),
    .raddr (idx),
    .rdata (tb_rdata)
  );
  assign {cone_ra, cone_sd, cone_cd, cone_cr} = tb_rdata;

  // shared multiplier, rounded half away from zero
  always_comb begin
    mul_a = PROD_W'(cone_sd);
    mul_b = PROD_W'(src_sin);
    unique case (state)
      S_MUL_A: begin
        mul_a = PROD_W'(cone_cd);
        mul_b = PROD_W'(src_cos);
      end
      S_MUL_P2: begin
        mul_a = prod_r;
        mul_b = PROD_W'(cdra);
      end
      default: ;
    endcase
    mag_a = mul_a[PROD_W-1] ? (PROD_W-1)'(-mul_a) : mul_a[PROD_W-2:0];
    mag_b = mul_b[PROD_W-1] ? (PROD_W-1)'(-mul_b) : mul_b[PROD_W-2:0];
    mag_p = mag_a * mag_b;
    mag_r = (mag_p + ((2*PROD_W-2)'(1) << (TRIG_FRAC_BITS - 1))) >> TRIG_FRAC_BITS;
    mul_round = (mul_a[PROD_W-1] ^ mul_b[PROD_W-1]) ? -signed'(PROD_W'(mag_r))
                                                    : signed'(PROD_W'(mag_r));
  end

  // great-circle test
  assign rhs = (PROD_W+2)'(p1_r) + (PROD_W+2)'(prod_r);
  assign hit = (PROD_W+2)'(cone_cr) <= rhs;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_acc) begin
          case (operation)
            OP_LOAD: state_next = slot_ok ? S_LD_DEC_GO : S_IDLE;
            OP_FIND: state_next = (n_eff == '0) ? S_OUT : S_SRC_GO;
            OP_EACH: state_next = (n_eff == '0) ? S_IDLE : S_SRC_GO;
            default: state_next = S_IDLE;
          endcase
        end
      end
      S_LD_DEC_GO:  state_next = S_LD_DEC_RUN;
      S_LD_DEC_RUN: if (c_done) state_next = S_LD_RAD_GO;
      S_LD_RAD_GO:  state_next = S_LD_RAD_RUN;
      S_LD_RAD_RUN: if (c_done) state_next = S_LD_WRITE;
      S_LD_WRITE:   state_next = S_IDLE;
      S_SRC_GO:     state_next = S_SRC_RUN;
      S_SRC_RUN:    if (c_done) state_next = S_RD_CONE;
      S_RD_CONE:    state_next = S_CONE_GO;
      S_CONE_GO:    state_next = S_CONE_RUN;
      S_CONE_RUN:   if (c_done) state_next = S_MUL_P1;
      S_MUL_P1:     state_next = S_MUL_A;
      S_MUL_A:      state_next = S_MUL_P2;
      S_MUL_P2:     state_next = S_CHECK;
      S_CHECK: begin
        if (op_r == OP_FIND) state_next = (hit || last_cone) ? S_OUT : S_RD_CONE;
        else state_next = S_OUT;
      end
      S_OUT: begin
        if (out_acc) state_next = (op_r == OP_FIND || last) ? S_IDLE : S_RD_CONE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_ready  = 1'b0;
    out_valid = 1'b0;
    c_start   = 1'b0;
    tb_we     = 1'b0;
    c_phase   = {dec_r, (PHASE_W-ANGLE_BITS)'(0)};
    idx_next  = idx;
    unique case (state)
      S_IDLE:      begin
        in_ready = 1'b1;
        idx_next = '0;
      end
      S_LD_DEC_GO: c_start = 1'b1;
      S_LD_RAD_GO: begin
        c_start = 1'b1;
        c_phase = {rad_r, (PHASE_W-ANGLE_BITS)'(0)};
      end
      S_LD_WRITE:  tb_we = 1'b1;
      S_SRC_GO:    c_start = 1'b1;
      S_CONE_GO:   begin
        c_start = 1'b1;
        c_phase = {cone_ra - ra_r, (PHASE_W-ANGLE_BITS)'(0)};
      end
      S_CHECK:     if (op_r == OP_FIND && !hit && !last_cone) idx_next = idx + 1'b1;
      S_OUT:       begin
        out_valid = 1'b1;
        if (out_acc && op_r != OP_FIND && !last) idx_next = idx + 1'b1;
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      idx    <= '0;
      origin <= 1'b0;
      active <= '0;
    end else begin
      state <= state_next;
      idx   <= idx_next;
      if (cfg_write) begin
        case (cfg_index)
          REG_ORIGIN: origin <= cfg_data[0];
          REG_ACTIVE: active <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  // item capture and working values
  always_ff @(posedge clk) begin
    if (in_acc) begin
      op_r   <= operation;
      slot_r <= entry_index;
      ra_r   <= ra_angle;
      dec_r  <= dec_angle;
      rad_r  <= radius_angle;
    end
    if (state == S_LD_DEC_RUN && c_done) begin
      ld_cos <= c_cos;
      ld_sin <= c_sin;
    end
    if (state == S_SRC_RUN && c_done) begin
      src_cos <= c_cos;
      src_sin <= c_sin;
    end
    if (state == S_CONE_RUN && c_done) cdra <= c_cos;
    prod_r <= mul_round;
    if (state == S_MUL_A) p1_r <= prod_r;
  end

  // result register
  always_ff @(posedge clk) begin
    if (state == S_IDLE && in_acc && operation == OP_FIND) begin
      any_match   <= 1'b0;
      match_index <= NO_MATCH;
      cone_flag   <= 1'b0;
      cone_number <= '0;
      last        <= 1'b1;
    end else if (state == S_CHECK) begin
      if (op_r == OP_FIND) begin
        any_match   <= hit;
        match_index <= hit ? INDEX_W'(idx) + INDEX_W'(origin) : NO_MATCH;
        cone_flag   <= 1'b0;
        cone_number <= '0;
        last        <= 1'b1;
      end else begin
        any_match   <= 1'b0;
        match_index <= '0;
        cone_flag   <= hit;
        cone_number <= NUM_W'(idx);
        last        <= last_cone;
      end
    end
  end

endmodule

// ===== sv/scm_checker.sv =====
`timescale 1ns / 1ps
module scm_checker (
  input logic                                  clk,
  input logic                                  rst,
  input logic                                  in_valid,
  input logic                                  in_ready,
  input logic [1:0]                            operation,
  input logic                                  out_valid,
  input logic                                  out_ready,
  input logic                                  any_match,
  input logic signed [scm_pkg::INDEX_W-1:0]    match_index,
  input logic                                  cone_flag,
  input logic [scm_pkg::NUM_W-1:0]             cone_number,
  input logic                                  last
);
  import scm_pkg::*;

  // one item in flight: never ready while a result is shown
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    !(in_ready && out_valid)) else $error("ready while result pending");

  // a load never produces a result right away
  a_load_quiet: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && operation == OP_LOAD |=> !out_valid)
    else $error("result after load item");

  // a hit in find mode carries a real index and no test-each fields
  a_find_fields: assert property (@(posedge clk) disable iff (rst)
    out_valid && any_match |-> match_index != NO_MATCH && !cone_flag && last)
    else $error("bad find result");

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(cone_number) && $stable(last))
    else $error("result changed while stalled");

endmodule

bind sky_cone_match_top scm_checker u_scm_checker (.*);
